>>> rtl/msit_pkg.sv
// Package for the multi-slot interval timer: operation and status codes,
// controller state type and default sizes. No dependencies.
`timescale 1ns / 1ps
package msit_pkg;
  localparam int SLOTS_DEF = 16;
  localparam int TIME_BITS_DEF = 32;
  localparam int RUN_BITS_DEF = 16;
  localparam int MAX_RESULTS = 16;

  typedef enum logic [3:0] {
    OP_SETUP = 4'd0, OP_DELETE = 4'd1, OP_CHANGE = 4'd2, OP_RESTART = 4'd3,
    OP_ENABLE = 4'd4, OP_DISABLE = 4'd5, OP_TOGGLE = 4'd6, OP_EN_ALL = 4'd7,
    OP_DIS_ALL = 4'd8, OP_TICK = 4'd9
  } op_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;
  localparam logic [1:0] ST_IDLE_TICK = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_OP, S_EXAM, S_DIV, S_UPD, S_OUT, S_FINAL
  } state_t;

  typedef struct packed {
    logic       load;       // capture input item
    logic       do_op;      // apply non-tick operation
    logic       div_start;  // launch divider
    logic       upd;        // commit tick result of slot
    logic       next_slot;  // advance scan pointer
    logic       emit;       // present the next recorded fire
    logic       final_load; // present the nothing-fired tick result
  } cmd_t;

  typedef struct packed {
    logic       is_tick;
    logic       scan_done;
    logic       expired;
    logic       need_div;
    logic       div_done;
    logic       any_fired;
    logic       emit_last;
    logic       out_busy;
  } sts_t;
endpackage

>>> rtl/msit_if.sv
// Valid/ready channel interface for the timer block.
// Carries a generic payload type; no dependencies.
`timescale 1ns / 1ps
interface msit_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/msit_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module msit_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0]  rem;
  logic [W-1:0]  dvd;
  logic [W-1:0]  dsr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    trial;

  assign trial = {rem, dvd[W-1]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        dvd  <= dividend;
        dsr  <= divisor;
        cnt  <= CW'(W);
      end else if (busy) begin
        if (!trial[W]) begin
          rem <= trial[W-1:0];
        end else begin
          rem <= {rem[W-2:0], dvd[W-1]};
        end
        dvd <= {dvd[W-2:0], ~trial[W]};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign quotient = dvd;
endmodule

>>> rtl/msit_ctrl.sv
// Controller state machine for the timer block.
// Depends on msit_pkg.
`timescale 1ns / 1ps
module msit_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  msit_pkg::sts_t sts,
  output msit_pkg::cmd_t cmd
);
  import msit_pkg::*;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_OP;
        end
      end
      S_OP: begin
        if (sts.is_tick) begin
          state_next = S_EXAM;
        end else if (!sts.out_busy) begin
          cmd.do_op = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_EXAM: begin
        if (sts.scan_done) begin
          state_next = sts.any_fired ? S_OUT : S_FINAL;
        end else if (!sts.expired) begin
          cmd.next_slot = 1'b1;
        end else if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end else begin
          state_next = S_UPD;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        cmd.next_slot = 1'b1;
        state_next = S_EXAM;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_FINAL: begin
        if (!sts.out_busy) begin
          cmd.final_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

>>> rtl/msit_dp.sv
// Datapath of the timer block: slot table, scan pointer, divider, fire record
// and the output register. Depends on msit_pkg and msit_div.
`timescale 1ns / 1ps
module msit_dp #(
  parameter int SLOTS = msit_pkg::SLOTS_DEF,
  parameter int TIME_BITS = msit_pkg::TIME_BITS_DEF,
  parameter int RUN_BITS = msit_pkg::RUN_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [3:0]     operation,
  input  logic [5:0]     slot,
  input  logic [31:0]    interval_ms,
  input  logic [15:0]    max_runs,
  input  logic [31:0]    now_ms,
  input  msit_pkg::cmd_t cmd,
  output msit_pkg::sts_t sts,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     status,
  output logic [5:0]     result_slot,
  output logic           fire,
  output logic           fire_and_delete,
  output logic           slot_enabled,
  output logic [6:0]     active_count,
  output logic           last
);
  import msit_pkg::*;
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW = $clog2(SLOTS + 1);
  localparam int NW = $clog2(MAX_RESULTS + 1);
  localparam int FW = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
  localparam int TW = TIME_BITS;
  localparam int RW = RUN_BITS;

  logic [SLOTS-1:0]  used, on;
  logic [TW-1:0]     period [SLOTS];
  logic [TW-1:0]     lastx  [SLOTS];
  logic [RW-1:0]     limit  [SLOTS];
  logic [RW-1:0]     count  [SLOTS];
  logic [PW-1:0]     total;

  logic [3:0]        op_r;
  logic [5:0]        slot_r;
  logic [TW-1:0]     ivl_r, now_r;
  logic [RW-1:0]     runs_r;
  logic [PW-1:0]     ptr;
  logic [NW-1:0]     nfired;
  logic [NW-1:0]     eidx;

  // Fires found during a scan, presented once the scan has finished so that
  // every result carries the count of used slots after the whole tick.
  logic [5:0]        fsl [MAX_RESULTS];
  logic              ffd [MAX_RESULTS];

  logic [TW-1:0]     quo;
  logic              div_done;

  // Operand capture (widths follow TIME_BITS and RUN_BITS).
  logic [TW-1:0] ivl_in, now_in;
  logic [RW-1:0] runs_in;
  localparam int TI = (TW < 32) ? TW : 32;
  localparam int RI = (RW < 16) ? RW : 16;
  always_comb begin
    ivl_in = '0;
    now_in = '0;
    runs_in = '0;
    ivl_in[TI-1:0] = interval_ms[TI-1:0];
    now_in[TI-1:0] = now_ms[TI-1:0];
    runs_in[RI-1:0] = max_runs[RI-1:0];
  end

  // Current scan slot.
  logic [IW-1:0] cur;
  logic [TW-1:0] cur_el;
  logic          scan_end;
  assign cur = ptr[IW-1:0];
  assign scan_end = (ptr >= PW'(SLOTS)) || (nfired >= NW'(MAX_RESULTS));
  assign cur_el = now_r - lastx[cur];

  // First free slot.
  logic [IW-1:0] free_idx;
  logic          full;
  always_comb begin
    free_idx = '0;
    full = 1'b1;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_idx = IW'(i);
        full = 1'b0;
      end
    end
  end

  logic          slot_ok;
  logic [IW-1:0] sidx;
  assign sidx = slot_r[IW-1:0];
  assign slot_ok = ({26'd0, slot_r} < 32'(SLOTS)) && used[sidx];

  // Tick decision for current slot.
  logic run_ok, is_last_run, fires;
  logic [RW-1:0] cnt_inc;
  assign cnt_inc = count[cur] + 1'b1;
  assign run_ok = (limit[cur] == '0) || (count[cur] < limit[cur]);
  assign is_last_run = (limit[cur] != '0) && (cnt_inc >= limit[cur]);
  assign fires = on[cur] && run_ok;

  logic [FW-1:0] eptr;
  logic          emit_last;
  assign eptr = eidx[FW-1:0];
  assign emit_last = ((eidx + 1'b1) == nfired);

  always_comb begin
    sts = '0;
    sts.is_tick   = (op_r == OP_TICK);
    sts.scan_done = scan_end;
    sts.expired   = used[cur] && (cur_el >= period[cur]);
    sts.need_div  = (period[cur] != '0);
    sts.div_done  = div_done;
    sts.any_fired = (nfired != '0);
    sts.emit_last = emit_last;
    sts.out_busy  = out_valid && !out_ready;
  end

  msit_div #(.W(TW)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(cur_el),
    .divisor(period[cur]), .done(div_done), .quotient(quo)
  );

  // Multiply period by quotient over a register; the product is only needed
  // modulo 2^TW, so the low half suffices. The divider leaves the quotient
  // stable until the next start.
  logic [TW-1:0] step_r;
  always_ff @(posedge clk) begin
    step_r <= TW'(period[cur] * quo);
  end
  // Zero-interval slot keeps its last-expiry time.
  logic [TW-1:0] new_last;
  assign new_last = (period[cur] != '0) ? (lastx[cur] + step_r) : lastx[cur];

  // Next contents of the output register.
  logic          o_load;
  logic [1:0]    o_st;
  logic [5:0]    o_sl;
  logic          o_f, o_fd, o_en, o_last;
  logic [PW-1:0] o_cnt;
  always_comb begin
    o_load = cmd.do_op || cmd.emit || cmd.final_load;
    o_st = ST_OK;
    o_sl = slot_r;
    o_f = 1'b0;
    o_fd = 1'b0;
    o_en = 1'b0;
    o_last = 1'b1;
    o_cnt = total;
    if (cmd.emit) begin
      o_sl = fsl[eptr];
      o_f = 1'b1;
      o_fd = ffd[eptr];
      o_en = !ffd[eptr];
      o_last = emit_last;
    end else if (cmd.final_load) begin
      o_st = ST_IDLE_TICK;
      o_sl = '0;
    end else begin
      case (op_r)
        OP_SETUP: begin
          if (full) begin
            o_st = ST_FULL;
            o_sl = '0;
          end else begin
            o_sl = 6'(free_idx);
            o_en = 1'b1;
            o_cnt = total + 1'b1;
          end
        end
        OP_DELETE, OP_CHANGE, OP_RESTART, OP_ENABLE, OP_DISABLE, OP_TOGGLE:
        begin
          if (!slot_ok) begin
            o_st = ST_BAD;
          end else begin
            case (op_r)
              OP_DELETE: o_cnt = total - 1'b1;
              OP_CHANGE, OP_RESTART: o_en = on[sidx];
              OP_ENABLE: o_en = 1'b1;
              OP_DISABLE: o_en = 1'b0;
              default: o_en = !on[sidx];
            endcase
          end
        end
        OP_EN_ALL, OP_DIS_ALL: o_sl = '0;
        default: o_st = ST_BAD;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (o_load) begin
      status <= o_st;
      result_slot <= o_sl;
      fire <= o_f;
      fire_and_delete <= o_fd;
      slot_enabled <= o_en;
      active_count <= 7'(o_cnt);
      last <= o_last;
    end
  end

  // Fire record, written in scan order.
  always_ff @(posedge clk) begin
    if (cmd.upd && fires) begin
      fsl[nfired[FW-1:0]] <= 6'(cur);
      ffd[nfired[FW-1:0]] <= is_last_run;
    end
  end

  // Slot table and sequencing registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      on <= '0;
      total <= '0;
      ptr <= '0;
      nfired <= '0;
      eidx <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        period[i] <= '0;
        lastx[i] <= '0;
        limit[i] <= '0;
        count[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        op_r <= operation;
        slot_r <= slot;
        ivl_r <= ivl_in;
        now_r <= now_in;
        runs_r <= runs_in;
        ptr <= '0;
        nfired <= '0;
        eidx <= '0;
      end
      if (cmd.do_op) begin
        case (op_r)
          OP_SETUP: begin
            if (!full) begin
              used[free_idx] <= 1'b1;
              on[free_idx] <= 1'b1;
              period[free_idx] <= ivl_r;
              lastx[free_idx] <= now_r;
              limit[free_idx] <= runs_r;
              count[free_idx] <= '0;
              total <= total + 1'b1;
            end
          end
          OP_DELETE, OP_CHANGE, OP_RESTART, OP_ENABLE, OP_DISABLE, OP_TOGGLE:
          begin
            if (slot_ok) begin
              case (op_r)
                OP_DELETE: begin
                  used[sidx] <= 1'b0;
                  on[sidx] <= 1'b0;
                  period[sidx] <= '0;
                  limit[sidx] <= '0;
                  count[sidx] <= '0;
                  lastx[sidx] <= now_r;
                  total <= total - 1'b1;
                end
                OP_CHANGE: begin
                  period[sidx] <= ivl_r;
                  lastx[sidx] <= now_r;
                end
                OP_RESTART: lastx[sidx] <= now_r;
                OP_ENABLE: on[sidx] <= 1'b1;
                OP_DISABLE: on[sidx] <= 1'b0;
                default: on[sidx] <= !on[sidx];
              endcase
            end
          end
          OP_EN_ALL, OP_DIS_ALL: begin
            for (int i = 0; i < SLOTS; i++) begin
              if (used[i] && limit[i] == '0) begin
                on[i] <= (op_r == OP_EN_ALL);
              end
            end
          end
          default: ;
        endcase
      end
      if (cmd.next_slot) begin
        ptr <= ptr + 1'b1;
      end
      if (cmd.upd) begin
        if (fires && is_last_run) begin
          used[cur] <= 1'b0;
          on[cur] <= 1'b0;
          period[cur] <= '0;
          limit[cur] <= '0;
          count[cur] <= '0;
          lastx[cur] <= now_r;
          total <= total - 1'b1;
        end else begin
          lastx[cur] <= new_last;
          if (fires && limit[cur] != '0) begin
            count[cur] <= cnt_inc;
          end
        end
        if (fires) begin
          nfired <= nfired + 1'b1;
        end
      end
      if (cmd.emit) begin
        eidx <= eidx + 1'b1;
      end
    end
  end
endmodule

>>> rtl/multi_slot_interval_timer_core.sv
// Multi-slot interval timer core: a table of timer slots driven by items
// carrying the current time. A non-tick item executes once it has been
// transferred and the output register is free, and its result is registered,
// so a new item is taken only after the previous one has executed. A tick
// scans the slots in order; an expired slot with a non-zero interval needs a
// bit-serial division before its update. The scan then closes and the results
// are presented one at a time, as the output accepts them. Synchronous reset
// clears the whole slot table.
`timescale 1ns / 1ps
module multi_slot_interval_timer_core #(
  parameter int SLOTS = msit_pkg::SLOTS_DEF,
  parameter int TIME_BITS = msit_pkg::TIME_BITS_DEF,
  parameter int RUN_BITS = msit_pkg::RUN_BITS_DEF
) (
  input logic clk,
  input logic rst,
  msit_if.sink   in_ch,
  msit_if.source out_ch
);
  import msit_pkg::*;
  cmd_t cmd;
  sts_t sts;

  // The controller sequences each item; the datapath holds the table. Fires
  // found by a tick are recorded during the scan and only transferred once it
  // has finished, because each result reports the slot count after the tick.
  msit_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  msit_dp #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS), .RUN_BITS(RUN_BITS)) u_dp (
    .clk(clk), .rst(rst),
    .operation(in_ch.data.operation), .slot(in_ch.data.slot),
    .interval_ms(in_ch.data.interval_ms), .max_runs(in_ch.data.max_runs),
    .now_ms(in_ch.data.now_ms), .cmd(cmd), .sts(sts),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .status(out_ch.data.status), .result_slot(out_ch.data.result_slot),
    .fire(out_ch.data.fire), .fire_and_delete(out_ch.data.fire_and_delete),
    .slot_enabled(out_ch.data.slot_enabled),
    .active_count(out_ch.data.active_count), .last(out_ch.data.last)
  );
endmodule
